>>> hw/rtl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned SizeW        = 13;
  localparam int unsigned KeyW         = 31;
  localparam int unsigned ValW         = 31;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 32;
  localparam logic [32:0] HashPrime    = 33'd4294967291;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_QUAD   = 2'd2,
    MODE_JUMP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_LIMIT = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE  = 3'd0,
    REG_MULT  = 3'd1,
    REG_ADD   = 3'd2,
    REG_SIZE  = 3'd3,
    REG_JMOD  = 3'd4,
    REG_LIMIT = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_MUL,
    ST_MODP,
    ST_MODS,
    ST_READ,
    ST_WAIT,
    ST_CHECK,
    ST_STEP,
    ST_WRAP,
    ST_WRITE,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic clr_start;  // start clear sweep
    logic clr_step;   // clear one entry
    logic mul;        // form the hash sum
    logic modp_step;  // fold toward the prime, key mod jump modulus
    logic mods_start; // start the size reduction
    logic mods_step;
    logic rd;         // issue memory read
    logic step;       // advance the probe position
    logic wrap;       // one reduction step of the position
    logic wr;         // write the entry
    logic fin;        // build result
    logic fin_limit;
    logic fin_range;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic func_ins;
    logic func_lkp;
    logic func_clr;
    logic direct;
    logic range_bad;
    logic clr_last;
    logic modp_done;
    logic mods_done;
    logic hit;        // empty slot or matching key
    logic at_limit;
    logic wrap_done;
  } stat_t;

endpackage

>>> hw/rtl/oaht_ctrl.sv
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer of one table transaction: hash, probe walk, write, result.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  oaht_pkg::stat_t  stat_i,
  output oaht_pkg::cmd_t   cmd_o
);
  import oaht_pkg::*;

  state_e state_q, state_d;

  // after reset the valid bits are swept before the first transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // result register is free when empty or being taken
  logic out_free;
  assign out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_o.fin) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (stat_i.func_clr) begin
          state_d = ST_CLEAR;
        end else if (!stat_i.func_ins && !stat_i.func_lkp) begin
          state_d = ST_DONE;
        end else if (stat_i.direct) begin
          state_d = stat_i.range_bad ? ST_DONE : ST_READ;
        end else begin
          state_d = ST_MODP;
        end
      end
      ST_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = ST_DONE;
        end
      end
      ST_MODP: begin
        if (stat_i.modp_done) begin
          state_d = ST_MODS;
        end
      end
      ST_MODS: begin
        if (stat_i.mods_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_WAIT;
      ST_WAIT:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (stat_i.direct || stat_i.hit) begin
          state_d = stat_i.func_ins ? ST_WRITE : ST_DONE;
        end else if (stat_i.at_limit) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_STEP:  state_d = ST_WRAP;
      ST_WRAP: begin
        if (stat_i.wrap_done) begin
          state_d = ST_READ;
        end
      end
      ST_WRITE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // the limit flag is held until the result is built
  logic lim_q, lim_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= 1'b0;
    end else begin
      lim_q <= lim_d;
    end
  end

  always_comb begin
    lim_d = lim_q;
    if (state_q == ST_IDLE) begin
      lim_d = 1'b0;
    end else if (state_q == ST_CHECK && !stat_i.direct && !stat_i.hit && stat_i.at_limit) begin
      lim_d = 1'b1;
    end
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_INIT:   cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_MUL: begin
        cmd_o.mul       = 1'b1;
        cmd_o.clr_start = stat_i.func_clr;
      end
      ST_CLEAR:  cmd_o.clr_step = 1'b1;
      ST_MODP: begin
        cmd_o.modp_step  = 1'b1;
        cmd_o.mods_start = stat_i.modp_done;
      end
      ST_MODS:   cmd_o.mods_step = 1'b1;
      ST_READ:   cmd_o.rd = 1'b1;
      ST_STEP:   cmd_o.step = 1'b1;
      ST_WRAP:   cmd_o.wrap = 1'b1;
      ST_WRITE:  cmd_o.wr = 1'b1;
      ST_DONE: begin
        cmd_o.fin       = out_free;
        cmd_o.fin_limit = lim_q;
        cmd_o.fin_range = stat_i.direct && stat_i.range_bad &&
                          (stat_i.func_ins || stat_i.func_lkp);
      end
      default: cmd_o = '0;
    endcase
  end

  a_one_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MUL)
    else $error("accept did not start a transaction");
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> state_q == ST_IDLE && out_valid_o)
    else $error("result not presented");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !cmd_o.load)
    else $error("accept while busy");

endmodule

>>> hw/rtl/oaht_dp.sv
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: hash arithmetic, probe position, slot memories and result.
// ----------------------------------------------------------------------------
module oaht_dp #(
  parameter int unsigned TABLE_ENTRIES = oaht_pkg::TableEntries
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     cfg_mode_i,
  input  logic [31:0]                    cfg_mult_i,
  input  logic [31:0]                    cfg_add_i,
  input  logic [oaht_pkg::SizeW-1:0]     cfg_size_i,
  input  logic [7:0]                     cfg_jmod_i,
  input  logic [oaht_pkg::SizeW-1:0]     cfg_limit_i,
  input  logic [1:0]                     in_func_i,
  input  logic [oaht_pkg::KeyW-1:0]      in_key_i,
  input  logic [oaht_pkg::ValW-1:0]      in_value_i,
  input  oaht_pkg::cmd_t                 cmd_i,
  output oaht_pkg::stat_t                stat_o,
  output logic                           found_o,
  output logic [oaht_pkg::ValW-1:0]      found_value_o,
  output logic [oaht_pkg::SizeW-1:0]     probe_count_o,
  output logic [1:0]                     status_o
);
  import oaht_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES);
  // position word: holds pos + stride before reduction
  localparam int unsigned AccW  = 40;

  // effective size: zero acts as 1, capped at the entries present
  logic [31:0] size_eff;
  always_comb begin
    if (cfg_size_i == '0) begin
      size_eff = 32'd1;
    end else if (32'(cfg_size_i) > 32'(TABLE_ENTRIES)) begin
      size_eff = 32'(TABLE_ENTRIES);
    end else begin
      size_eff = 32'(cfg_size_i);
    end
  end

  logic [1:0]      func_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [7:0]      jump_q;     // 1 + key mod jm, up to 255
  logic [63:0]     hsum_q;     // key * mult + add, folded toward the prime

  // 2^32 is 5 modulo the prime: three folds bring the sum below 2^32
  logic [63:0] fold;
  logic [32:0] hmod;
  always_comb begin
    fold = (64'(hsum_q[63:32]) << 2) + 64'(hsum_q[63:32]) + 64'(hsum_q[31:0]);
    hmod = (hsum_q[32:0] >= HashPrime) ? hsum_q[32:0] - HashPrime : hsum_q[32:0];
  end

  logic [7:0] jm;
  assign jm = (cfg_jmod_i == '0) ? 8'd1 : cfg_jmod_i;

  // restoring remainder of the hash by the size, one bit a cycle
  logic [32:0]    rem_q;       // shifting dividend
  logic [SizeW:0] part_q;      // partial remainder
  logic [5:0]     bit_q;
  logic [SizeW:0] part_sh;
  logic [SizeW:0] dvs;

  always_comb begin
    dvs     = (SizeW+1)'(size_eff);
    part_sh = {part_q[SizeW-1:0], rem_q[32]};
  end

  // key mod jm: 31 serial steps during the fold cycles
  logic [KeyW-1:0] kr_q;
  logic [8:0]      kp_q;
  logic [8:0]      kp_sh;
  logic [4:0]      kbit_q;
  assign kp_sh = {kp_q[7:0], kr_q[KeyW-1]};

  logic [AccW-1:0]  pos_q;
  logic [SizeW-1:0] cnt_q;
  logic             modp_done, mods_done;

  assign modp_done = (kbit_q == 5'd0);
  assign mods_done = (bit_q == 6'd0);

  // stride of the next probe move
  logic [13:0] nxt_cnt;
  logic [27:0] quad_stride;
  logic [21:0] jump_stride;
  always_comb begin
    nxt_cnt     = {1'b0, cnt_q} + 14'd1;
    quad_stride = 28'(nxt_cnt) * 28'(nxt_cnt);
    jump_stride = 22'(nxt_cnt) * 22'(jump_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      key_q  <= in_key_i;
      val_q  <= in_value_i;
      cnt_q  <= '0;
    end
    if (cmd_i.mul) begin
      // sum fits in 64 bits without carry loss
      hsum_q <= 64'(key_q) * 64'(cfg_mult_i) + 64'(cfg_add_i);
      pos_q  <= AccW'(key_q[AddrW-1:0]);  // direct mode slot
      kr_q   <= key_q;
      kp_q   <= '0;
      kbit_q <= 5'd31;
    end
    if (cmd_i.modp_step) begin
      hsum_q <= fold;
      if (kbit_q != 5'd0) begin
        kr_q   <= {kr_q[KeyW-2:0], 1'b0};
        kbit_q <= kbit_q - 5'd1;
        kp_q   <= (kp_sh >= 9'(jm)) ? kp_sh - 9'(jm) : kp_sh;
      end else begin
        jump_q <= kp_q[7:0] + 8'd1;
      end
    end
    if (cmd_i.mods_start) begin
      rem_q  <= hmod;
      part_q <= '0;
      bit_q  <= 6'd33;
    end else if (cmd_i.mods_step && bit_q != 6'd0) begin
      rem_q  <= {rem_q[31:0], 1'b0};
      bit_q  <= bit_q - 6'd1;
      part_q <= (part_sh >= dvs) ? part_sh - dvs : part_sh;
    end
    if (cmd_i.mods_step && bit_q == 6'd0) begin
      pos_q <= AccW'(part_q);
    end
    if (cmd_i.step) begin
      cnt_q <= cnt_q + 1'b1;
      case (mode_e'(cfg_mode_i))
        MODE_LINEAR: pos_q <= pos_q + 40'd1;
        MODE_QUAD:   pos_q <= pos_q + 40'(quad_stride);
        MODE_JUMP:   pos_q <= pos_q + 40'(jump_stride);
        default:     pos_q <= pos_q + 40'd1;
      endcase
    end
    // conditional subtraction of size times 8192, 64 or 1 keeps the step count small
    if (cmd_i.wrap) begin
      if (pos_q >= (40'(size_eff) << 13)) begin
        pos_q <= pos_q - (40'(size_eff) << 13);
      end else if (pos_q >= (40'(size_eff) << 6)) begin
        pos_q <= pos_q - (40'(size_eff) << 6);
      end else if (pos_q >= 40'(size_eff)) begin
        pos_q <= pos_q - 40'(size_eff);
      end
    end
  end

  logic wrap_done;
  assign wrap_done = pos_q < 40'(size_eff);

  // clear sweep over the valid bits, one entry a cycle
  logic [AddrW:0]   clr_q;
  logic [AddrW-1:0] addr;
  assign addr = pos_q[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  logic            vld_mem [TABLE_ENTRIES];
  logic [KeyW-1:0] key_mem [TABLE_ENTRIES];
  logic [ValW-1:0] val_mem [TABLE_ENTRIES];
  logic [KeyW-1:0] rkey_q;
  logic [ValW-1:0] rval_q;
  logic            rvld_q;
  logic            vld_we;
  logic [AddrW-1:0] vld_addr;

  assign vld_we   = cmd_i.clr_step || cmd_i.wr;
  assign vld_addr = cmd_i.clr_step ? clr_q[AddrW-1:0] : addr;

  always_ff @(posedge clk_i) begin
    if (vld_we) begin
      vld_mem[vld_addr] <= cmd_i.wr;
    end
    if (cmd_i.wr) begin
      key_mem[addr] <= key_q;
      val_mem[addr] <= val_q;
    end
    if (cmd_i.rd) begin
      rkey_q <= key_mem[addr];
      rval_q <= val_mem[addr];
      rvld_q <= vld_mem[addr];
    end
  end

  logic direct;
  assign direct = (mode_e'(cfg_mode_i) == MODE_DIRECT);

  always_comb begin
    stat_o           = '0;
    stat_o.func_ins  = (func_e'(func_q) == FUNC_INSERT);
    stat_o.func_lkp  = (func_e'(func_q) == FUNC_LOOKUP);
    stat_o.func_clr  = (func_e'(func_q) == FUNC_CLEAR);
    stat_o.direct    = direct;
    stat_o.range_bad = 32'(key_q) >= size_eff;
    stat_o.clr_last  = (clr_q == (AddrW+1)'(TABLE_ENTRIES - 1));
    stat_o.modp_done = modp_done;
    stat_o.mods_done = mods_done;
    stat_o.hit       = !rvld_q || (rkey_q == key_q);
    stat_o.at_limit  = cnt_q >= cfg_limit_i;
    stat_o.wrap_done = wrap_done;
  end

  logic ok_op;
  assign ok_op = (func_e'(func_q) == FUNC_INSERT) || (func_e'(func_q) == FUNC_LOOKUP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      found_o       <= 1'b0;
      found_value_o <= '0;
      probe_count_o <= '0;
      status_o      <= STAT_OK;
      if (cmd_i.fin_range) begin
        status_o <= STAT_RANGE;
      end else if (cmd_i.fin_limit) begin
        status_o      <= STAT_LIMIT;
        probe_count_o <= cnt_q;
      end else if (ok_op) begin
        probe_count_o <= cnt_q;
        if (func_e'(func_q) == FUNC_INSERT) begin
          found_o       <= 1'b1;
          found_value_o <= val_q;
        end else if (rvld_q) begin
          found_o       <= 1'b1;
          found_value_o <= rval_q;
        end
      end
    end
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> pos_q < 40'(size_eff))
    else $error("probe position beyond size");
  a_write_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> direct || !rvld_q || rkey_q == key_q)
    else $error("write to a slot that holds another key");
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> cnt_q < cfg_limit_i)
    else $error("probe beyond limit");

endmodule

>>> hw/rtl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Key-value table with universal hash and linear, quadratic or jump probing, or direct indexing.
// ----------------------------------------------------------------------------
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready  func, key, value
// m_axis    out  m_axis_tvalid/m_axis_tready  found, found_value, probe_count, status
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// hashed transaction: hash product, folds toward the prime that also form the
// jump stride, a 33-step size remainder and the home slot read; each probe
// move adds a stride step, the wrap subtractions and a slot read.
// direct transaction: a single slot read. clear: a sweep over all entries.
// after reset a sweep empties the table with s_axis_tready low; one
// transaction at a time, the result register holds while m_axis_tready is low.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
  parameter int unsigned TABLE_ENTRIES = oaht_pkg::TableEntries
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,  // func, key, value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata,  // found, found_value, probe_count, status
  input  logic                           cfg_we_i,
  input  logic [oaht_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [oaht_pkg::CfgDataW-1:0]  cfg_data_i
);
  import oaht_pkg::*;

  logic [1:0]       mode_q;
  logic [31:0]      mult_q, add_q;
  logic [SizeW-1:0] size_q, limit_q;
  logic [7:0]       jmod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_QUAD;
      mult_q  <= 32'd1;
      add_q   <= '0;
      size_q  <= SizeW'(4096);
      jmod_q  <= 8'd41;
      limit_q <= SizeW'(1000);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_MODE:  mode_q  <= cfg_data_i[1:0];
        REG_MULT:  mult_q  <= cfg_data_i;
        REG_ADD:   add_q   <= cfg_data_i;
        REG_SIZE:  size_q  <= cfg_data_i[SizeW-1:0];
        REG_JMOD:  jmod_q  <= cfg_data_i[7:0];
        REG_LIMIT: limit_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  cmd_t  cmd;
  stat_t stat;
  logic             found;
  logic [ValW-1:0]  found_value;
  logic [SizeW-1:0] probe_count;
  logic [1:0]       status;

  oaht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  oaht_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_mode_i    (mode_q),
    .cfg_mult_i    (mult_q),
    .cfg_add_i     (add_q),
    .cfg_size_i    (size_q),
    .cfg_jmod_i    (jmod_q),
    .cfg_limit_i   (limit_q),
    .in_func_i     (s_axis_tdata[1:0]),
    .in_key_i      (s_axis_tdata[32:2]),
    .in_value_i    (s_axis_tdata[63:33]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .found_o       (found),
    .found_value_o (found_value),
    .probe_count_o (probe_count),
    .status_o      (status)
  );

  assign m_axis_tdata = {1'b0, status, probe_count, found_value, found};

endmodule
